>>> rtl/tkid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tkid_pkg;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_ALT  = 2'd2;

    localparam logic [4:0] KEY_HOME   = 5'd0;
    localparam logic [4:0] KEY_END    = 5'd1;
    localparam logic [4:0] KEY_INSERT = 5'd2;
    localparam logic [4:0] KEY_DELETE = 5'd3;
    localparam logic [4:0] KEY_PGUP   = 5'd4;
    localparam logic [4:0] KEY_PGDN   = 5'd5;
    localparam logic [4:0] KEY_UP     = 5'd6;
    localparam logic [4:0] KEY_DOWN   = 5'd7;
    localparam logic [4:0] KEY_RIGHT  = 5'd8;
    localparam logic [4:0] KEY_LEFT   = 5'd9;
    localparam logic [4:0] KEY_F1     = 5'd10;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [4:0]  key_id;
        logic [30:0] char_value;
        logic        last_of_run;
    } tkid_event_t;

    // results caused by one input byte
    typedef struct packed {
        logic [1:0]  count;
        tkid_event_t first;
        tkid_event_t second;
    } tkid_step_t;

    typedef struct packed {
        logic        hit;
        logic [4:0]  id;
    } tkid_match_t;

    function automatic tkid_match_t tkid_match_key(
        input logic [7:0] fin,
        input logic       intro_is_o,
        input logic       second_bracket,
        input logic [7:0] arg
    );
        tkid_match_t m;
        m.hit = 1'b1;
        m.id  = KEY_HOME;
        if (fin == "H") begin
            m.id = KEY_HOME;
        end
        else if (fin == "F") begin
            m.id = KEY_END;
        end
        else if (intro_is_o) begin
            m.hit = fin inside {["P":"S"]};
            m.id  = KEY_F1 + 5'(fin - 8'h50);
        end
        else if (second_bracket) begin
            m.hit = fin inside {["A":"E"]};
            m.id  = KEY_F1 + 5'(fin - 8'h41);
        end
        else begin
            case (fin)
                "A": m.id = KEY_UP;
                "B": m.id = KEY_DOWN;
                "C": m.id = KEY_RIGHT;
                "D": m.id = KEY_LEFT;
                CH_TILDE:
                begin
                    case (arg)
                        8'd1:  m.id = KEY_HOME;
                        8'd2:  m.id = KEY_INSERT;
                        8'd3:  m.id = KEY_DELETE;
                        8'd4:  m.id = KEY_END;
                        8'd5:  m.id = KEY_PGUP;
                        8'd6:  m.id = KEY_PGDN;
                        8'd15: m.id = KEY_F1 + 5'd4;
                        8'd17: m.id = KEY_F1 + 5'd5;
                        8'd18: m.id = KEY_F1 + 5'd6;
                        8'd19: m.id = KEY_F1 + 5'd7;
                        8'd20: m.id = KEY_F1 + 5'd8;
                        8'd21: m.id = KEY_F1 + 5'd9;
                        8'd23: m.id = KEY_F1 + 5'd10;
                        8'd24: m.id = KEY_F1 + 5'd11;
                        default: m.hit = 1'b0;
                    endcase
                end
                default: m.hit = 1'b0;
            endcase
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tkid_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface tkid_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface tkid_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [4:0]  key_id;
    logic [30:0] char_value;
    logic        last_of_run;

    modport source (output valid, output event_kind, output key_id, output char_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input key_id, input char_value,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/tkid_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tkid_parser
    import tkid_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] in_byte,
    output tkid_step_t      step
);

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_UTF8   = 5'b00010,
        MODE_ESC    = 5'b00100,
        MODE_INTRO  = 5'b01000,
        MODE_DIGITS = 5'b10000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [2:0]  remaining_reg, remaining_next;
    logic [30:0] accum_reg, accum_next;
    logic        intro_o_reg, intro_o_next;
    logic        bracket2_reg, bracket2_next;
    logic [7:0]  arg_reg, arg_next;

    logic        is_digit;
    logic [30:0] accum_shift;
    logic [2:0]  remaining_dec;
    logic [11:0] arg_wide;
    logic [11:0] arg_sum;
    logic [7:0]  arg_sat;
    tkid_match_t match;

    assign is_digit      = in_byte inside {["0":"9"]};
    assign accum_shift   = {accum_reg[24:0], in_byte[5:0]};
    assign remaining_dec = remaining_reg - 3'd1;
    assign arg_wide      = {4'd0, arg_reg};
    assign arg_sum       = (arg_wide << 3) + (arg_wide << 1) + {8'd0, in_byte[3:0]};
    assign arg_sat       = (arg_sum > 12'd255) ? 8'hFF : arg_sum[7:0];
    assign match         = tkid_match_key(in_byte, intro_o_reg, bracket2_reg, arg_reg);

    always_comb
    begin
        logic        fin_code;
        logic [30:0] code;
        logic        fin_seq;
        fin_code       = 1'b0;
        code           = '0;
        fin_seq        = 1'b0;
        mode_next      = mode_reg;
        remaining_next = remaining_reg;
        accum_next     = accum_reg;
        intro_o_next   = intro_o_reg;
        bracket2_next  = bracket2_reg;
        arg_next       = arg_reg;
        step           = '0;

        case (mode_reg)
            MODE_UTF8:
            begin
                if (in_byte[7:6] != 2'b10) begin
                    fin_code = 1'b1;
                    code     = {23'd0, CH_QMARK};
                end
                else if (remaining_dec == 3'd0) begin
                    fin_code = 1'b1;
                    code     = accum_shift;
                end
                else begin
                    accum_next     = accum_shift;
                    remaining_next = remaining_dec;
                end
            end
            MODE_ESC:
            begin
                if (in_byte == CH_O || in_byte == CH_LBRACK) begin
                    intro_o_next  = (in_byte == CH_O);
                    bracket2_next = 1'b0;
                    arg_next      = '0;
                    mode_next     = MODE_INTRO;
                end
                else begin
                    mode_next               = MODE_IDLE;
                    step.count              = 2'd1;
                    step.first.event_kind   = KIND_ALT;
                    step.first.char_value   = {23'd0, in_byte};
                    step.first.last_of_run  = 1'b1;
                end
            end
            MODE_INTRO:
            begin
                if (in_byte == CH_LBRACK) begin
                    bracket2_next = 1'b1;
                    mode_next     = MODE_DIGITS;
                end
                else if (is_digit) begin
                    arg_next  = arg_sat;
                    mode_next = MODE_DIGITS;
                end
                else begin
                    fin_seq = 1'b1;
                end
            end
            MODE_DIGITS:
            begin
                if (is_digit) begin
                    arg_next = arg_sat;
                end
                else begin
                    fin_seq = 1'b1;
                end
            end
            default:
            begin
                // start of a character: plain ASCII, a UTF-8 lead byte, or an invalid byte that gives '?'
                mode_next = MODE_UTF8;
                if (!in_byte[7]) begin
                    fin_code = 1'b1;
                    code     = {23'd0, in_byte};
                end
                else if ((in_byte & 8'hE0) == 8'hC0) begin
                    accum_next     = {26'd0, in_byte[4:0]};
                    remaining_next = 3'd1;
                end
                else if ((in_byte & 8'hF0) == 8'hE0) begin
                    accum_next     = {27'd0, in_byte[3:0]};
                    remaining_next = 3'd2;
                end
                else if ((in_byte & 8'hF8) == 8'hF0) begin
                    accum_next     = {28'd0, in_byte[2:0]};
                    remaining_next = 3'd3;
                end
                else if ((in_byte & 8'hFC) == 8'hF8) begin
                    accum_next     = {29'd0, in_byte[1:0]};
                    remaining_next = 3'd4;
                end
                else if ((in_byte & 8'hFE) == 8'hFC) begin
                    accum_next     = {30'd0, in_byte[0]};
                    remaining_next = 3'd5;
                end
                else begin
                    fin_code = 1'b1;
                    code     = {23'd0, CH_QMARK};
                end
            end
        endcase

        if (fin_code) begin
            remaining_next = '0;
            accum_next     = '0;
            if (code == {23'd0, CH_ESC}) begin
                mode_next = MODE_ESC;
            end
            else begin
                mode_next              = MODE_IDLE;
                step.count             = 2'd1;
                step.first.event_kind  = KIND_CHAR;
                step.first.char_value  = (code == {23'd0, CH_NL}) ? {23'd0, CH_CR} : code;
                step.first.last_of_run = 1'b1;
            end
        end

        if (fin_seq) begin
            mode_next     = MODE_IDLE;
            intro_o_next  = 1'b0;
            bracket2_next = 1'b0;
            arg_next      = '0;
            if (match.hit) begin
                step.count             = 2'd1;
                step.first.event_kind  = KIND_KEY;
                step.first.key_id      = match.id;
                step.first.last_of_run = 1'b1;
            end
            else begin
                // unmatched: ESC then the intro byte, digits and final byte dropped
                step.count              = 2'd2;
                step.first.event_kind   = KIND_CHAR;
                step.first.char_value   = {23'd0, CH_ESC};
                step.second.event_kind  = KIND_CHAR;
                step.second.char_value  = {23'd0, intro_o_reg ? CH_O : CH_LBRACK};
                step.second.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_IDLE;
            remaining_reg <= '0;
            accum_reg     <= '0;
            intro_o_reg   <= 1'b0;
            bracket2_reg  <= 1'b0;
            arg_reg       <= '0;
        end
        else if (take) begin
            mode_reg      <= mode_next;
            remaining_reg <= remaining_next;
            accum_reg     <= accum_next;
            intro_o_reg   <= intro_o_next;
            bracket2_reg  <= bracket2_next;
            arg_reg       <= arg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tkid_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tkid_out_queue
    import tkid_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire tkid_step_t step,
    output logic            has_room,
    output logic            out_valid,
    input  wire logic       out_ready,
    output tkid_event_t     out_event
);

    // two entries, each holding all results of one byte
    tkid_step_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       phase_reg;

    tkid_step_t head;
    logic       do_push;
    logic       pop_entry;
    logic       head_done;

    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && (step.count != 2'd0);
    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_event = phase_reg ? head.second : head.first;
    assign head_done = phase_reg || (head.count != 2'd2);
    assign pop_entry = out_valid && out_ready && head_done;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (out_valid && out_ready) begin
                phase_reg <= !head_done;
            end
            if (pop_entry) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, pop_entry};
        end
    end

endmodule

`default_nettype wire

>>> rtl/terminal_key_input_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel     Modport  Payload                                          Transaction
// term_bytes  sink     in_byte[7:0]                                     one terminal byte
// key_events  source   event_kind[1:0] key_id[4:0] char_value[30:0]     one key event
//                      last_of_run
//
// Each byte is decoded in the cycle it is accepted; its results enter the result queue.
// One byte per cycle is taken while the sink keeps up; an unmatched escape makes two
// results, so the output port sets the rate at one result per cycle.
// A two-entry result queue absorbs output stalls; term_bytes.ready drops only when full.
// rst_n is asynchronous and returns the parser to idle with an empty queue.

module terminal_key_input_decoder
    import tkid_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tkid_byte_if.sink     term_bytes,
    tkid_event_if.source  key_events
);

    logic        take;
    logic        has_room;
    tkid_step_t  step;
    tkid_event_t out_event;

    assign term_bytes.ready = has_room;
    assign take             = term_bytes.valid && has_room;

    tkid_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (term_bytes.in_byte),
        .step    (step)
    );

    tkid_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .step      (step),
        .has_room  (has_room),
        .out_valid (key_events.valid),
        .out_ready (key_events.ready),
        .out_event (out_event)
    );

    assign key_events.event_kind  = out_event.event_kind;
    assign key_events.key_id      = out_event.key_id;
    assign key_events.char_value  = out_event.char_value;
    assign key_events.last_of_run = out_event.last_of_run;

endmodule

`default_nettype wire

>>> rtl/tkid_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tkid_checker
    import tkid_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  event_kind,
    input wire logic [4:0]  key_id,
    input wire logic [30:0] char_value,
    input wire logic        last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(event_kind) && $stable(key_id)
                                    && $stable(char_value) && $stable(last_of_run))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with nothing to deliver");

    a_key_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_KEY |-> key_id == 5'd0)
        else $error("key id set on a non-key event");

    a_key_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_KEY |-> last_of_run && char_value == 31'd0)
        else $error("key event not the only result of its byte");

endmodule

bind terminal_key_input_decoder tkid_checker u_tkid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (term_bytes.ready),
    .out_valid   (key_events.valid),
    .out_ready   (key_events.ready),
    .event_kind  (key_events.event_kind),
    .key_id      (key_events.key_id),
    .char_value  (key_events.char_value),
    .last_of_run (key_events.last_of_run)
);

`default_nettype wire
